/* src/mime_transfer_decoder_core_defines.svh */
// Assertion macros shared by the decoder modules.
// Needs nothing else; each user file pulls this in by include.
`ifndef MIME_TRANSFER_DECODER_CORE_DEFINES_SVH
`define MIME_TRANSFER_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define MTD_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("mtd assertion failed");

// Next-cycle implication, checked outside reset.
`define MTD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("mtd assertion failed");

`endif

/* src/mtd_pkg.sv */
// Shared types, codes and character tables of the transfer decoder.
// No dependencies; imported by every decoder module.
package mtd_pkg;

  localparam int MODE_W  = 3;
  localparam int Q_DEPTH = 4;
  localparam int Q_PTR_W = $clog2(Q_DEPTH);
  localparam int Q_CNT_W = $clog2(Q_DEPTH + 1);

  localparam logic [MODE_W-1:0] MODE_7BIT   = 3'd0;
  localparam logic [MODE_W-1:0] MODE_8BIT   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_BASE64 = 3'd2;
  localparam logic [MODE_W-1:0] MODE_BINARY = 3'd3;
  localparam logic [MODE_W-1:0] MODE_QP     = 3'd4;

  localparam logic [1:0] ST_BYTE = 2'd0;
  localparam logic [1:0] ST_END  = 2'd1;
  localparam logic [1:0] ST_ERR  = 2'd2;

  localparam logic [1:0] ESC_NONE = 2'd0;
  localparam logic [1:0] ESC_EQ   = 2'd1;
  localparam logic [1:0] ESC_HIGH = 2'd2;

  localparam logic [7:0] CH_LF  = 8'h0A;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_SP  = 8'h20;
  localparam logic [7:0] CH_EQ  = 8'h3D;
  localparam logic [7:0] CH_NUL = 8'h00;

  localparam logic [6:0] B64_PAD = 7'd64;
  localparam logic [6:0] B64_BAD = 7'd65;
  localparam logic [4:0] HEX_BAD = 5'd16;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_input;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] status;
    logic       last;
  } out_item_t;

  // One queued command: up to three results of one accepted item.
  typedef struct packed {
    logic [1:0] cnt;
    logic [1:0] status;
    logic [7:0] b0;
    logic [7:0] b1;
    logic [7:0] b2;
  } cmd_t;

  function automatic logic [6:0] b64_value(input logic [7:0] c);
    logic [7:0] v;
    v = {1'b0, B64_BAD};
    if (c >= 8'h41 && c <= 8'h5A) v = c - 8'h41;
    else if (c >= 8'h61 && c <= 8'h7A) v = c - 8'h61 + 8'd26;
    else if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30 + 8'd52;
    else if (c == 8'h2B) v = 8'd62;
    else if (c == 8'h2F) v = 8'd63;
    else if (c == CH_EQ) v = {1'b0, B64_PAD};
    return v[6:0];
  endfunction

  // Upper-case hex digits only.
  function automatic logic [4:0] hex_value(input logic [7:0] c);
    logic [7:0] v;
    v = {3'b000, HEX_BAD};
    if (c >= 8'h30 && c <= 8'h39) v = c - 8'h30;
    else if (c >= 8'h41 && c <= 8'h46) v = c - 8'h41 + 8'd10;
    return v[4:0];
  endfunction

endpackage

/* src/mtd_front.sv */
// Front end: accepts input beats, holds the decoding state and turns each
// item into at most one queued command. Depends on mtd_pkg.
module mtd_front import mtd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata,
  input  logic              q_full,
  output logic              push,
  output cmd_t              cmd
);

  logic [MODE_W-1:0] mode_r;
  logic [1:0]        grp_r, grp_nxt;
  logic [23:0]       acc_r, acc_nxt;
  logic [1:0]        pad_r, pad_nxt;
  logic [1:0]        esc_r, esc_nxt;
  logic [3:0]        hi_r, hi_nxt;

  logic [7:0]  c;
  logic [6:0]  v;
  logic [4:0]  h;
  logic [1:0]  pad_n;
  logic [23:0] acc_n;
  logic        err;
  logic        clr;
  logic        busy;
  logic        accept;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign c        = in_data.data_byte;
  assign v        = b64_value(c);
  assign h        = hex_value(c);
  assign busy     = (mode_r == MODE_BASE64 && (grp_r != 2'd0 || pad_r != 2'd0)) ||
                    (mode_r == MODE_QP && esc_r != ESC_NONE);

  always_comb begin
    grp_nxt = grp_r;
    acc_nxt = acc_r;
    pad_nxt = pad_r;
    esc_nxt = esc_r;
    hi_nxt  = hi_r;
    cmd     = '0;
    err     = 1'b0;
    clr     = 1'b0;
    pad_n   = pad_r;
    acc_n   = acc_r;
    if (mode_r > MODE_QP) begin
      err = 1'b1;
    end else if (in_data.end_of_input) begin
      cmd.cnt    = 2'd1;
      cmd.status = busy ? ST_ERR : ST_END;
      clr        = 1'b1;
    end else begin
      unique case (mode_r)
        MODE_7BIT: begin
          if (c[7] || c == CH_NUL) err = 1'b1;
          else begin
            cmd.cnt = 2'd1;
            cmd.b0  = c;
          end
        end
        MODE_8BIT: begin
          if (c == CH_NUL) err = 1'b1;
          else begin
            cmd.cnt = 2'd1;
            cmd.b0  = c;
          end
        end
        MODE_BINARY: begin
          cmd.cnt = 2'd1;
          cmd.b0  = c;
        end
        MODE_BASE64: begin
          // newline is skipped outright
          if (c == CH_LF) begin
          end else if (v == B64_BAD) begin
            err = 1'b1;
          end else begin
            if (v == B64_PAD) begin
              if (grp_r < 2'd2) err = 1'b1;
              else pad_n = pad_r + 2'd1;
            end else begin
              if (pad_r != 2'd0) err = 1'b1;
              else acc_n = {acc_r[17:0], v[5:0]};
            end
            if (!err) begin
              if (grp_r != 2'd3) begin
                grp_nxt = grp_r + 2'd1;
                pad_nxt = pad_n;
                acc_nxt = acc_n;
              end else if (pad_n == 2'd0) begin
                cmd.cnt = 2'd3;
                cmd.b0  = acc_n[23:16];
                cmd.b1  = acc_n[15:8];
                cmd.b2  = acc_n[7:0];
                clr     = 1'b1;
              end else if (pad_n == 2'd1) begin
                // slop bits of the third sextet must be zero
                if (acc_n[1:0] != 2'd0) err = 1'b1;
                else begin
                  cmd.cnt = 2'd2;
                  cmd.b0  = acc_n[17:10];
                  cmd.b1  = acc_n[9:2];
                  clr     = 1'b1;
                end
              end else begin
                if (acc_n[3:0] != 4'd0) err = 1'b1;
                else begin
                  cmd.cnt = 2'd1;
                  cmd.b0  = acc_n[11:4];
                  clr     = 1'b1;
                end
              end
            end
          end
        end
        MODE_QP: begin
          unique case (esc_r)
            ESC_NONE: begin
              if (c == CH_EQ) esc_nxt = ESC_EQ;
              else if (c == CH_SP || c == CH_TAB || c == CH_LF ||
                       (c >= 8'd33 && c <= 8'd126)) begin
                cmd.cnt = 2'd1;
                cmd.b0  = c;
              end else err = 1'b1;
            end
            ESC_EQ: begin
              // soft line break: drop both
              if (c == CH_LF) esc_nxt = ESC_NONE;
              else if (h == HEX_BAD) err = 1'b1;
              else begin
                hi_nxt  = h[3:0];
                esc_nxt = ESC_HIGH;
              end
            end
            default: begin
              if (h == HEX_BAD) err = 1'b1;
              else begin
                cmd.cnt = 2'd1;
                cmd.b0  = {hi_r, h[3:0]};
                clr     = 1'b1;
              end
            end
          endcase
        end
        default: err = 1'b1;
      endcase
    end
    if (err) begin
      cmd        = '0;
      cmd.cnt    = 2'd1;
      cmd.status = ST_ERR;
      clr        = 1'b1;
    end
    if (clr) begin
      grp_nxt = 2'd0;
      acc_nxt = '0;
      pad_nxt = 2'd0;
      esc_nxt = ESC_NONE;
      hi_nxt  = 4'd0;
    end
  end

  assign push = accept && cmd.cnt != 2'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_7BIT;
      grp_r  <= 2'd0;
      acc_r  <= '0;
      pad_r  <= 2'd0;
      esc_r  <= ESC_NONE;
      hi_r   <= 4'd0;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
      grp_r  <= 2'd0;
      acc_r  <= '0;
      pad_r  <= 2'd0;
      esc_r  <= ESC_NONE;
      hi_r   <= 4'd0;
    end else if (accept) begin
      grp_r <= grp_nxt;
      acc_r <= acc_nxt;
      pad_r <= pad_nxt;
      esc_r <= esc_nxt;
      hi_r  <= hi_nxt;
    end
  end

endmodule

/* src/mtd_queue.sv */
// Short command queue between front and back ends.
// Depends on mtd_pkg and the assertion macro header.
`include "mime_transfer_decoder_core_defines.svh"
module mtd_queue import mtd_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic head_valid,
  output cmd_t head_cmd
);

  cmd_t               entries_r [Q_DEPTH];
  logic [Q_PTR_W-1:0] wp_r, wp_nxt;
  logic [Q_PTR_W-1:0] rp_r, rp_nxt;
  logic [Q_CNT_W-1:0] cnt_r, cnt_nxt;

  assign full       = cnt_r == Q_CNT_W'(Q_DEPTH);
  assign head_valid = cnt_r != '0;
  assign head_cmd   = entries_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push) wp_nxt = (wp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wp_r + 1'b1;
    if (pop)  rp_nxt = (rp_r == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rp_r + 1'b1;
    if (push && !pop) cnt_nxt = cnt_r + 1'b1;
    else if (pop && !push) cnt_nxt = cnt_r - 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) entries_r[wp_r] <= push_cmd;
  end

  `MTD_ASSERT_IMPLIES(a_no_overflow, clk, rst_n, push, cnt_r != Q_CNT_W'(Q_DEPTH))
  `MTD_ASSERT_IMPLIES(a_no_underflow, clk, rst_n, pop, cnt_r != '0)

endmodule

/* src/mtd_back.sv */
// Back end: unrolls queued commands into result beats through an output
// register. Depends on mtd_pkg and the assertion macro header.
`include "mime_transfer_decoder_core_defines.svh"
module mtd_back import mtd_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      q_valid,
  input  cmd_t      q_head,
  output logic      pop,
  output logic      out_valid,
  input  logic      out_ready,
  output out_item_t out_data
);

  cmd_t      cmd_r;
  logic      cmd_valid_r;
  logic [1:0] idx_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic      load;
  logic      last_beat;
  logic      slot_free;
  logic [7:0] beat_byte;

  assign load      = cmd_valid_r && (!out_valid_r || out_ready);
  assign last_beat = idx_r == (cmd_r.cnt - 2'd1);
  assign slot_free = !cmd_valid_r || (load && last_beat);
  assign pop       = q_valid && slot_free;

  always_comb begin
    case (idx_r)
      2'd0:    beat_byte = cmd_r.b0;
      2'd1:    beat_byte = cmd_r.b1;
      default: beat_byte = cmd_r.b2;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cmd_valid_r <= 1'b0;
      idx_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (pop) begin
        cmd_valid_r <= 1'b1;
        idx_r       <= 2'd0;
      end else if (load && last_beat) begin
        cmd_valid_r <= 1'b0;
      end else if (load) begin
        idx_r <= idx_r + 2'd1;
      end
      if (load) out_valid_r <= 1'b1;
      else if (out_ready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cmd_r <= q_head;
    if (load) begin
      out_data_r.out_byte <= beat_byte;
      out_data_r.status   <= cmd_r.status;
      out_data_r.last     <= last_beat;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  `MTD_ASSERT_IMPLIES(a_cmd_nonempty, clk, rst_n, cmd_valid_r, cmd_r.cnt != 2'd0)
  `MTD_ASSERT_IMPLIES(a_status_last, clk, rst_n, out_valid_r && out_data_r.status != ST_BYTE, out_data_r.last)

endmodule

/* src/mime_transfer_decoder_core.sv */
// MIME transfer-encoding decoder (7bit, 8bit, binary, quoted-printable,
// base64). The block takes one input beat per clock unless the queue is full,
// and a result beat leaves one per clock while out_ready is high. The results
// of an item (up to three for a full base64 group) pass through the queue
// entry, the command register and the output register. A four-entry command
// queue sits between the ends, so input stalls only when that queue fills,
// which base64 never does in steady state with out_ready high (three results
// per four symbols). Input is taken right out of reset; there is no clearing
// pass. Write cfg_wdata (the mode) only while idle; a write clears any partial
// group or escape. Depends on mtd_pkg, mtd_front, mtd_queue and mtd_back.
module mime_transfer_decoder_core import mtd_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_we,
  input  logic [MODE_W-1:0] cfg_wdata
);

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic head_valid;
  cmd_t head_cmd;

  mtd_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .q_full    (q_full),
    .push      (push),
    .cmd       (push_cmd)
  );

  mtd_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_cmd   (push_cmd),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_cmd   (head_cmd)
  );

  mtd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_valid   (head_valid),
    .q_head    (head_cmd),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule
